@@ rtl/salc_pkg.sv @@
`timescale 1ns / 1ps

package salc_pkg;

    localparam int DEF_SET_INDEX_BITS = 6;
    localparam int DEF_NUM_WAYS       = 8;

    localparam int ADDR_W      = 64;
    localparam int TAG_W       = 64;
    localparam int STAMP_W     = 64;
    localparam int COUNT_W     = 32;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;
    localparam int IDX_BITS_W  = 3;
    localparam int OFF_BITS_W  = 6;
    localparam int WAYS_W      = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hffff_ffff;

    // Reset values of the configuration registers
    localparam logic [IDX_BITS_W-1:0] RST_INDEX_BITS  = 3'd4;
    localparam logic [OFF_BITS_W-1:0] RST_OFFSET_BITS = 6'd4;
    localparam logic [WAYS_W-1:0]     RST_WAYS_IN_USE = 4'd1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_STORE  = 2'd1,
        OP_MODIFY = 2'd2,
        OP_FETCH  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INDEX_BITS  = 2'd0,
        REG_OFFSET_BITS = 2'd1,
        REG_WAYS_IN_USE = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // One cache line as held in a set row of the line memory
    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } line_t;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic lookup;
        logic scan_step;
        logic evict_wr;
        logic push;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_fetch;
        logic need_scan;
        logic scan_done;
        logic out_free;
    } ctrl_status_t;

endpackage

@@ rtl/set_associative_lru_cache_model.sv @@
`timescale 1ns / 1ps

// Set-associative cache model with LRU replacement. Each load, store or modify
// transaction is looked up in its set and returns one result: hit, eviction and
// the saturating hit/miss/eviction totals. Instruction fetches are accepted and
// give no result. One set row (valid, tag and stamp of every way) is read from
// the line memory, the ways are compared in parallel and the row is written
// back: a hit or a fill goes through accept, lookup and result. An eviction
// walks the stamps of the active ways one per cycle between lookup and result.
// A stalled result holds the block in its result state. After reset the line
// memory is cleared one set per cycle, all 2**SET_INDEX_BITS sets, and no
// transaction is taken until it is done; configuration writes are taken at
// any time but must only be made while the block is idle.
module set_associative_lru_cache_model
    import salc_pkg::*;
#(
    parameter int SET_INDEX_BITS = DEF_SET_INDEX_BITS,
    parameter int NUM_WAYS       = DEF_NUM_WAYS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [OP_W-1:0]       op,
    input  logic [ADDR_W-1:0]     address,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  was_hit,
    output logic                  was_evicted,
    output logic [COUNT_W-1:0]    hits_total,
    output logic [COUNT_W-1:0]    misses_total,
    output logic [COUNT_W-1:0]    evictions_total,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    salc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    salc_datapath #(
        .SET_INDEX_BITS (SET_INDEX_BITS),
        .NUM_WAYS       (NUM_WAYS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .op              (op),
        .address         (address),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .was_hit         (was_hit),
        .was_evicted     (was_evicted),
        .hits_total      (hits_total),
        .misses_total    (misses_total),
        .evictions_total (evictions_total),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

endmodule

@@ rtl/salc_ram.sv @@
`timescale 1ns / 1ps

module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/salc_ctrl.sv @@
`timescale 1ns / 1ps

module salc_ctrl
    import salc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    // fetches are dropped on the spot
                    if (!status.is_fetch)
                    begin
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = status.need_scan ? ST_SCAN : ST_RESULT;
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    cmd.evict_wr = 1'b1;
                    state_next   = ST_RESULT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/salc_datapath.sv @@
`timescale 1ns / 1ps

module salc_datapath
    import salc_pkg::*;
#(
    parameter int SET_INDEX_BITS = DEF_SET_INDEX_BITS,
    parameter int NUM_WAYS       = DEF_NUM_WAYS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output ctrl_status_t          status,
    input  logic [OP_W-1:0]       op,
    input  logic [ADDR_W-1:0]     address,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic                  was_hit,
    output logic                  was_evicted,
    output logic [COUNT_W-1:0]    hits_total,
    output logic [COUNT_W-1:0]    misses_total,
    output logic [COUNT_W-1:0]    evictions_total,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NUM_SETS = 1 << SET_INDEX_BITS;
    localparam int ROW_AW   = (SET_INDEX_BITS > 0) ? SET_INDEX_BITS : 1;
    localparam int SB_W     = (SET_INDEX_BITS > 0) ? $clog2(SET_INDEX_BITS + 1) : 1;
    localparam int WC_W     = $clog2(NUM_WAYS + 1);
    localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int ROW_W    = NUM_WAYS * $bits(line_t);
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(NUM_SETS - 1);

    typedef line_t [NUM_WAYS-1:0] row_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // configuration
    logic [IDX_BITS_W-1:0] index_bits_reg;
    logic [OFF_BITS_W-1:0] offset_bits_reg;
    logic [WAYS_W-1:0]     ways_in_use_reg;
    logic [SB_W-1:0]       sbits_eff;
    logic [WC_W-1:0]       ways_eff;

    // control state
    logic [ROW_AW-1:0]  clear_cnt_reg;
    logic [STAMP_W-1:0] access_clock_reg;
    logic [COUNT_W-1:0] hit_count_reg;
    logic [COUNT_W-1:0] miss_count_reg;
    logic [COUNT_W-1:0] eviction_count_reg;
    logic               out_valid_reg;
    logic               out_hit_reg;
    logic               out_evict_reg;

    // per-access payload
    logic [ROW_AW-1:0]  set_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic               modify_reg;
    logic               hit_reg;
    logic               evict_reg;
    logic [WC_W-1:0]    scan_way_reg;
    logic [WAY_W-1:0]   pick_reg;

    logic [ADDR_W-1:0]  shifted;
    logic [ROW_AW-1:0]  set_mask;
    logic [ROW_AW-1:0]  set_in;
    logic [TAG_W-1:0]   tag_in;

    row_t               row;
    row_t               lookup_row;
    row_t               evict_row;
    logic               hit_any;
    logic               inv_any;
    logic [WAY_W-1:0]   hit_way;
    logic [WAY_W-1:0]   inv_way;
    logic               scan_less;

    logic               ram_we;
    logic [ROW_AW-1:0]  ram_waddr;
    logic [ROW_W-1:0]   ram_wdata;
    logic [ROW_W-1:0]   ram_rdata;

    logic [COUNT_W-1:0] hits_mod;
    logic [COUNT_W-1:0] hits_next;
    logic [COUNT_W-1:0] misses_next;
    logic [COUNT_W-1:0] evictions_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (int'(index_bits_reg) > SET_INDEX_BITS)
        begin
            sbits_eff = SB_W'(SET_INDEX_BITS);
        end
        else
        begin
            sbits_eff = SB_W'(index_bits_reg);
        end

        if (ways_in_use_reg == '0)
        begin
            ways_eff = WC_W'(1);
        end
        else if (int'(ways_in_use_reg) > NUM_WAYS)
        begin
            ways_eff = WC_W'(NUM_WAYS);
        end
        else
        begin
            ways_eff = WC_W'(ways_in_use_reg);
        end
    end

    // Address split; tag bits past the top of the address shift in as zero.
    assign shifted  = address >> offset_bits_reg;
    assign set_mask = ~({ROW_AW{1'b1}} << sbits_eff);
    assign set_in   = shifted[ROW_AW-1:0] & set_mask;
    assign tag_in   = shifted >> sbits_eff;

    assign row = row_t'(ram_rdata);

    // Parallel tag compare and first free way of the active ways
    always_comb
    begin
        hit_any    = 1'b0;
        inv_any    = 1'b0;
        hit_way    = '0;
        inv_way    = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (WC_W'(w) < ways_eff)
            begin
                if (row[w].valid && (row[w].tag == tag_reg))
                begin
                    hit_any = 1'b1;
                    hit_way = WAY_W'(w);
                end
                if (!row[w].valid)
                begin
                    inv_any = 1'b1;
                    inv_way = WAY_W'(w);
                end
            end
        end

        lookup_row = row;
        if (hit_any)
        begin
            lookup_row[hit_way].stamp = access_clock_reg;
        end
        else
        begin
            lookup_row[inv_way].valid = 1'b1;
            lookup_row[inv_way].tag   = tag_reg;
            lookup_row[inv_way].stamp = access_clock_reg;
        end

        evict_row                 = row;
        evict_row[pick_reg].tag   = tag_reg;
        evict_row[pick_reg].stamp = access_clock_reg;
    end

    assign scan_less = row[scan_way_reg[WAY_W-1:0]].stamp < row[pick_reg].stamp;

    always_comb
    begin
        ram_we    = cmd.clear_wr || cmd.evict_wr || (cmd.lookup && (hit_any || inv_any));
        ram_waddr = cmd.clear_wr ? clear_cnt_reg : set_reg;
        if (cmd.clear_wr)
        begin
            ram_wdata = '0;
        end
        else if (cmd.evict_wr)
        begin
            ram_wdata = ROW_W'(evict_row);
        end
        else
        begin
            ram_wdata = ROW_W'(lookup_row);
        end
    end

    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.accept),
        .raddr (set_in),
        .rdata (ram_rdata)
    );

    // A modify counts one hit ahead of its own lookup.
    always_comb
    begin
        hits_mod       = modify_reg ? sat_inc(hit_count_reg) : hit_count_reg;
        hits_next      = hit_reg ? sat_inc(hits_mod) : hits_mod;
        misses_next    = hit_reg ? miss_count_reg : sat_inc(miss_count_reg);
        evictions_next = evict_reg ? sat_inc(eviction_count_reg) : eviction_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg     <= RST_INDEX_BITS;
            offset_bits_reg    <= RST_OFFSET_BITS;
            ways_in_use_reg    <= RST_WAYS_IN_USE;
            clear_cnt_reg      <= '0;
            access_clock_reg   <= '0;
            hit_count_reg      <= '0;
            miss_count_reg     <= '0;
            eviction_count_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_INDEX_BITS:  index_bits_reg  <= cfg_data[IDX_BITS_W-1:0];
                    REG_OFFSET_BITS: offset_bits_reg <= cfg_data[OFF_BITS_W-1:0];
                    REG_WAYS_IN_USE: ways_in_use_reg <= cfg_data[WAYS_W-1:0];
                    default:         ;
                endcase
            end

            if (cmd.clear_wr)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end

            if (cmd.push)
            begin
                out_valid_reg      <= 1'b1;
                access_clock_reg   <= access_clock_reg + 1'b1;
                hit_count_reg      <= hits_next;
                miss_count_reg     <= misses_next;
                eviction_count_reg <= evictions_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            set_reg    <= set_in;
            tag_reg    <= tag_in;
            modify_reg <= (op == OP_MODIFY);
        end

        if (cmd.lookup)
        begin
            hit_reg      <= hit_any;
            evict_reg    <= 1'b0;
            pick_reg     <= '0;
            scan_way_reg <= WC_W'(1);
        end

        // walk the ways, keep the oldest stamp, lowest way on ties
        if (cmd.scan_step)
        begin
            if (scan_less)
            begin
                pick_reg <= scan_way_reg[WAY_W-1:0];
            end
            scan_way_reg <= scan_way_reg + 1'b1;
        end

        if (cmd.evict_wr)
        begin
            evict_reg <= 1'b1;
        end

        // hold the result flags while the next transaction is looked up
        if (cmd.push)
        begin
            out_hit_reg   <= hit_reg;
            out_evict_reg <= evict_reg;
        end
    end

    always_comb
    begin
        status.clear_done = (clear_cnt_reg == LAST_ROW);
        status.is_fetch   = (op == OP_FETCH);
        status.need_scan  = !hit_any && !inv_any;
        status.scan_done  = (scan_way_reg >= ways_eff);
        status.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid       = out_valid_reg;
    assign was_hit         = out_hit_reg;
    assign was_evicted     = out_evict_reg;
    assign hits_total      = hit_count_reg;
    assign misses_total    = miss_count_reg;
    assign evictions_total = eviction_count_reg;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import salc_pkg::*;

    localparam int SETS_LOG      = DEF_SET_INDEX_BITS;
    localparam int WAYS_MAX      = DEF_NUM_WAYS;
    localparam int LINE_COUNT    = (1 << SETS_LOG) * WAYS_MAX;
    localparam int SETTLE_CYCLES = 3 + WAYS_MAX + 10;
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_ITEMS   = 180;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct {
        op_t               kind;
        logic [ADDR_W-1:0] addr;
    } access_t;

    typedef struct {
        logic               hit;
        logic               evicted;
        logic [COUNT_W-1:0] hits;
        logic [COUNT_W-1:0] misses;
        logic [COUNT_W-1:0] evictions;
    } outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [OP_W-1:0]       op = OP_LOAD;
    logic [ADDR_W-1:0]     address = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  was_hit;
    logic                  was_evicted;
    logic [COUNT_W-1:0]    hits_total;
    logic [COUNT_W-1:0]    misses_total;
    logic [COUNT_W-1:0]    evictions_total;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_INDEX_BITS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Stimulus and expectations
    access_t  access_q[$];
    access_t  next_access;
    outcome_t access_outcomes[$];
    outcome_t oldest;

    // Cache image kept alongside the block
    logic               valid_bits [LINE_COUNT];
    logic [TAG_W-1:0]   tag_mem    [LINE_COUNT];
    logic [STAMP_W-1:0] stamp_mem  [LINE_COUNT];
    logic [STAMP_W-1:0] access_clock;
    logic [COUNT_W-1:0] hit_tally;
    logic [COUNT_W-1:0] miss_tally;
    logic [COUNT_W-1:0] evict_tally;
    int unsigned        m_index_bits;
    int unsigned        m_offset_bits;
    int unsigned        m_ways;

    int mismatches = 0;
    int results_seen = 0;
    int hits_seen = 0;
    int evicts_seen = 0;
    int fetches_seen = 0;
    int settings_count = 1;
    int cycle_count = 0;
    int sent_count;
    int gap_left;
    int steady_in;
    int stall_left;
    int steady_out;
    int next_hold_at;
    int stall_pick;
    int k;

    set_associative_lru_cache_model u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .address         (address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .was_hit         (was_hit),
        .was_evicted     (was_evicted),
        .hits_total      (hits_total),
        .misses_total    (misses_total),
        .evictions_total (evictions_total),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench failed");
            $finish;
        end
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [COUNT_W-1:0] sat_up(logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // Look one access up in the cache image and queue the result it causes
    function automatic void cache_access(op_t kind, logic [ADDR_W-1:0] addr);
        int unsigned       sbits;
        int unsigned       ways;
        int unsigned       base;
        int unsigned       pick;
        int unsigned       w;
        logic [ADDR_W-1:0] set_no;
        logic [TAG_W-1:0]  tag_val;
        logic              hit;
        logic              evicted;
        logic              placed;
        outcome_t          res;

        if (kind == OP_FETCH)
        begin
            fetches_seen++;
            return;
        end
        hit = 1'b0;
        evicted = 1'b0;
        placed = 1'b0;
        if (kind == OP_MODIFY)
            hit_tally = sat_up(hit_tally);

        sbits = (m_index_bits > SETS_LOG) ? SETS_LOG : m_index_bits;
        ways = (m_ways == 0) ? 1 : ((m_ways > WAYS_MAX) ? WAYS_MAX : m_ways);
        set_no = (m_offset_bits < 64) ? (addr >> m_offset_bits) : '0;
        set_no = set_no & ((64'd1 << sbits) - 64'd1);
        tag_val = (m_offset_bits + sbits < 64) ? (addr >> (m_offset_bits + sbits)) : '0;
        base = 32'(set_no) * WAYS_MAX;

        for (w = 0; w < ways; w++)
        begin
            if (!hit && valid_bits[base + w] && tag_mem[base + w] == tag_val)
            begin
                stamp_mem[base + w] = access_clock;
                hit = 1'b1;
            end
        end

        if (hit)
            hit_tally = sat_up(hit_tally);
        else
        begin
            miss_tally = sat_up(miss_tally);
            for (w = 0; w < ways; w++)
            begin
                if (!placed && !valid_bits[base + w])
                begin
                    valid_bits[base + w] = 1'b1;
                    tag_mem[base + w] = tag_val;
                    stamp_mem[base + w] = access_clock;
                    placed = 1'b1;
                end
            end
            if (!placed)
            begin
                // oldest stamp loses; strict compare keeps the lowest way on ties
                pick = 0;
                for (w = 1; w < ways; w++)
                begin
                    if (stamp_mem[base + w] < stamp_mem[base + pick])
                        pick = w;
                end
                tag_mem[base + pick] = tag_val;
                stamp_mem[base + pick] = access_clock;
                evicted = 1'b1;
                evict_tally = sat_up(evict_tally);
            end
        end
        access_clock = access_clock + 1'b1;

        res.hit = hit;
        res.evicted = evicted;
        res.hits = hit_tally;
        res.misses = miss_tally;
        res.evictions = evict_tally;
        access_outcomes.push_back(res);
    endfunction

    // Input side: one transaction per slot, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op <= OP_LOAD;
            address <= '0;
            gap_left <= 0;
            steady_in <= 0;
            sent_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                sent_count <= sent_count + 1;
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (access_q.size() > 0)
                begin
                    next_access = access_q.pop_front();
                    in_valid <= 1'b1;
                    op <= next_access.kind;
                    address <= next_access.addr;
                    if (steady_in > 0)
                    begin
                        steady_in <= steady_in - 1;
                        gap_left <= 0;
                    end
                    else
                    begin
                        gap_left <= pick_idle();
                        if ($urandom_range(0, 39) == 0)
                            steady_in <= 80;
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result side stall: short random stalls, plain stretches, and long holds
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
            steady_out <= 0;
            next_hold_at <= 500;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (sent_count >= next_hold_at)
        begin
            // hold long enough for the block to back up into its input
            out_stall <= 1'b1;
            stall_left <= LONG_HOLD - 1;
            next_hold_at <= next_hold_at + 900;
        end
        else if (steady_out > 0)
        begin
            out_stall <= 1'b0;
            steady_out <= steady_out - 1;
        end
        else
        begin
            stall_pick = pick_idle();
            out_stall <= (stall_pick != 0);
            stall_left <= (stall_pick != 0) ? stall_pick - 1 : 0;
            if ($urandom_range(0, 39) == 0)
                steady_out <= 80;
        end
    end

    // Watch all three channels: check results, track settings, model accesses
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (k = 0; k < LINE_COUNT; k++)
            begin
                valid_bits[k] = 1'b0;
                tag_mem[k] = '0;
                stamp_mem[k] = '0;
            end
            access_clock = '0;
            hit_tally = '0;
            miss_tally = '0;
            evict_tally = '0;
            m_index_bits = 32'(RST_INDEX_BITS);
            m_offset_bits = 32'(RST_OFFSET_BITS);
            m_ways = 32'(RST_WAYS_IN_USE);
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (was_hit === 1'b1)
                    hits_seen++;
                if (was_evicted === 1'b1)
                    evicts_seen++;
                if (access_outcomes.size() == 0)
                begin
                    $error("result transaction with nothing expected: hit %0b evicted %0b",
                           was_hit, was_evicted);
                    mismatches++;
                end
                else
                begin
                    oldest = access_outcomes.pop_front();
                    if (was_hit !== oldest.hit)
                    begin
                        $error("was_hit: expected %0b, got %0b", oldest.hit, was_hit);
                        mismatches++;
                    end
                    if (was_evicted !== oldest.evicted)
                    begin
                        $error("was_evicted: expected %0b, got %0b", oldest.evicted, was_evicted);
                        mismatches++;
                    end
                    if (hits_total !== oldest.hits)
                    begin
                        $error("hits_total: expected %0d, got %0d", oldest.hits, hits_total);
                        mismatches++;
                    end
                    if (misses_total !== oldest.misses)
                    begin
                        $error("misses_total: expected %0d, got %0d", oldest.misses, misses_total);
                        mismatches++;
                    end
                    if (evictions_total !== oldest.evictions)
                    begin
                        $error("evictions_total: expected %0d, got %0d",
                               oldest.evictions, evictions_total);
                        mismatches++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_INDEX_BITS:  m_index_bits = 32'(cfg_data[IDX_BITS_W-1:0]);
                    REG_OFFSET_BITS: m_offset_bits = 32'(cfg_data[OFF_BITS_W-1:0]);
                    REG_WAYS_IN_USE: m_ways = 32'(cfg_data[WAYS_W-1:0]);
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                cache_access(op_t'(op), address);
        end
    end

    task automatic push_access(op_t kind, logic [ADDR_W-1:0] addr);
        access_t item;
        item.kind = kind;
        item.addr = addr;
        access_q.push_back(item);
    endtask

    // Drain: everything sent, every result back, then let a trailing fetch finish
    task automatic wait_idle();
        do
            @(negedge clk);
        while (access_q.size() != 0 || in_valid || access_outcomes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t which, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_cache(int ib, int ob, int wu);
        write_reg(REG_INDEX_BITS, CFG_DATA_W'(ib));
        write_reg(REG_OFFSET_BITS, CFG_DATA_W'(ob));
        write_reg(REG_WAYS_IN_USE, CFG_DATA_W'(wu));
        settings_count++;
        @(negedge clk);
    endtask

    // Random accesses, mostly drawn from a small pool of lines so that sets fill,
    // hit and evict; the rest are wild addresses and fetches
    task automatic add_random(int ib, int ob, int wu, int count);
        logic [ADDR_W-1:0] pool[$];
        logic [ADDR_W-1:0] set_pick[4];
        logic [ADDR_W-1:0] offmask;
        logic [ADDR_W-1:0] tag_v;
        logic [ADDR_W-1:0] a;
        int                sb;
        int                wy;
        int                nsets;
        int                slots;
        int                r;
        int                i;

        @(negedge clk);
        sb = (ib > SETS_LOG) ? SETS_LOG : ib;
        wy = (wu == 0) ? 1 : ((wu > WAYS_MAX) ? WAYS_MAX : wu);
        nsets = $urandom_range(1, 4);
        if (nsets > (1 << sb))
            nsets = 1 << sb;
        slots = nsets * (wy + 2);
        offmask = (ob >= 64) ? '1 : ((64'd1 << ob) - 64'd1);
        for (i = 0; i < 4; i++)
            set_pick[i] = ADDR_W'($urandom_range(0, (1 << sb) - 1));
        for (i = 0; i < slots; i++)
        begin
            tag_v = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : ADDR_W'(i / nsets);
            a = '0;
            if (ob < 64)
                a = a | (set_pick[i % nsets] << ob);
            if (ob + sb < 64)
                a = a | (tag_v << (ob + sb));
            pool.push_back(a);
        end
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                push_access(OP_FETCH, {$urandom, $urandom});
            else if (r < 20)
                push_access(op_t'($urandom_range(0, 2)), {$urandom, $urandom});
            else
                push_access(op_t'($urandom_range(0, 2)),
                            pool[$urandom_range(0, slots - 1)] ^ ({$urandom, $urandom} & offmask));
        end
    endtask

    initial
    begin : stimulus
        int rib;
        int rob;
        int rwu;
        int n;

        @(posedge rst_n);
        @(negedge clk);

        // Reset settings: one way, sixteen sets, sixteen-byte lines
        push_access(OP_LOAD, 64'h0);
        push_access(OP_LOAD, 64'h0);
        push_access(OP_STORE, 64'hF);
        push_access(OP_MODIFY, 64'h10);
        push_access(OP_MODIFY, 64'h1F);
        push_access(OP_FETCH, 64'h0);
        push_access(OP_FETCH, '1);
        push_access(OP_LOAD, '1);
        push_access(OP_STORE, 64'h100);
        push_access(OP_LOAD, 64'h0);
        push_access(OP_LOAD, '1);
        push_access(OP_STORE, 64'h8000_0000_0000_0000);
        push_access(OP_MODIFY, 64'h5555_5555_5555_5555);
        push_access(OP_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
        add_random(int'(RST_INDEX_BITS), int'(RST_OFFSET_BITS), int'(RST_WAYS_IN_USE),
                   PHASE_ITEMS);
        wait_idle();

        // Four ways in set 0: five tags loaded, refreshed and evicted by age
        program_cache(2, 0, 4);
        push_access(OP_LOAD, 64'h4);
        push_access(OP_LOAD, 64'h8);
        push_access(OP_STORE, 64'hC);
        push_access(OP_LOAD, 64'h10);
        push_access(OP_LOAD, 64'h4);
        push_access(OP_STORE, 64'h14);
        push_access(OP_LOAD, 64'h8);
        push_access(OP_MODIFY, 64'h10);
        add_random(2, 0, 4, PHASE_ITEMS);
        wait_idle();

        program_cache(0, 0, 8);
        add_random(0, 0, 8, PHASE_ITEMS);
        wait_idle();

        program_cache(6, 58, 8);
        add_random(6, 58, 8, PHASE_ITEMS);
        wait_idle();

        program_cache(7, 63, 0);
        add_random(7, 63, 0, PHASE_ITEMS);
        wait_idle();

        program_cache(6, 6, 15);
        add_random(6, 6, 15, PHASE_ITEMS);
        wait_idle();

        program_cache(3, 60, 2);
        add_random(3, 60, 2, PHASE_ITEMS);
        wait_idle();

        program_cache(5, 12, 8);
        add_random(5, 12, 8, PHASE_ITEMS);
        wait_idle();

        for (n = 0; n < 3; n++)
        begin
            rib = $urandom_range(0, 7);
            rob = $urandom_range(0, 63);
            rwu = $urandom_range(0, 15);
            program_cache(rib, rob, rwu);
            add_random(rib, rob, rwu, PHASE_ITEMS);
            wait_idle();
        end

        $display("Ran %0d accesses (%0d instruction fetches) across %0d cache settings",
                 sent_count, fetches_seen, settings_count);
        $display("Checked %0d results: %0d hits, %0d evictions, %0d mismatches",
                 results_seen, hits_seen, evicts_seen, mismatches);
        if (mismatches == 0 && access_outcomes.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/salc_pkg.sv
rtl/salc_ram.sv
rtl/salc_ctrl.sv
rtl/salc_datapath.sv
rtl/set_associative_lru_cache_model.sv
dv/testbench.sv
